/* rtl/twg_pkg.sv */
// Shared constants, types and the sine quarter-wave table of the waveform generator.
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;

    // register indexes on the configuration port
    localparam t_cfg_index REG_RUN_ENABLE    = 2'd0;
    localparam t_cfg_index REG_WAVE_SELECT   = 2'd1;
    localparam t_cfg_index REG_RELOAD_PERIOD = 2'd2;
    localparam t_cfg_index REG_AMPLITUDE     = 2'd3;

    typedef logic [1:0] t_wave;

    localparam t_wave WAVE_SINE     = 2'd0;
    localparam t_wave WAVE_SQUARE   = 2'd1;
    localparam t_wave WAVE_TRIANGLE = 2'd2;
    localparam t_wave WAVE_FLAT     = 2'd3;

    localparam logic [15:0] RELOAD_PERIOD_RESET = 16'd2249;
    localparam logic [15:0] AMPLITUDE_RESET     = 16'd32768;

    // Q1.15 quarter sine, nine points from 0 to pi/2
    function automatic logic [15:0] quarter_sine(input logic [3:0] r);
        logic [15:0] q;
        case (r)
            4'd0:    q = 16'd0;
            4'd1:    q = 16'd6393;
            4'd2:    q = 16'd12540;
            4'd3:    q = 16'd18205;
            4'd4:    q = 16'd23170;
            4'd5:    q = 16'd27246;
            4'd6:    q = 16'd30274;
            4'd7:    q = 16'd32138;
            4'd8:    q = 16'd32768;
            default: q = 16'd0;
        endcase
        return q;
    endfunction

    // signed Q2.15 sine of a 32-point table entry
    function automatic logic signed [16:0] sine_q15(input logic [4:0] k);
        logic [3:0]         r;
        logic [3:0]         r_mirror;
        logic signed [16:0] mag;
        logic signed [16:0] s;
        r        = {1'b0, k[2:0]};
        r_mirror = 4'd8 - r;
        case (k[4:3])
            2'd0:    mag = $signed({1'b0, quarter_sine(r)});
            2'd1:    mag = $signed({1'b0, quarter_sine(r_mirror)});
            2'd2:    mag = $signed({1'b0, quarter_sine(r)});
            default: mag = $signed({1'b0, quarter_sine(r_mirror)});
        endcase
        s = k[4] ? -mag : mag;
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/twg_if.sv */
// Handshake channel interfaces for tick requests, sample results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface twg_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface twg_sample_if #(
    parameter int DAC_BITS = 12,
    parameter int PHASE_W  = 5
);
    logic                valid;
    logic                ready;
    logic [DAC_BITS-1:0] sample;
    logic [PHASE_W-1:0]  phase;

    modport source (output valid, output sample, output phase, input ready);
    modport sink   (input valid, input sample, input phase, output ready);
endinterface

interface twg_cfg_if;
    logic                 valid;
    logic                 ready;
    twg_pkg::t_cfg_index  index;
    twg_pkg::t_cfg_data   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/table_waveform_generator.sv */
// Top level of the table waveform generator: reload counter, sample pipeline, result queue.
`timescale 1ns / 1ps
`default_nettype none

// Timer-driven DAC sample source. Every accepted tick request with tick set advances a
// reload counter while run_enable is 1; the tick that finds the counter at reload_period
// (or above it) returns it to zero and emits one sample for the current table point, then
// advances the point index modulo POINTS. A tick request is taken every clock cycle while
// ready is high; a sample passes the input register, counter stage, two multiply stages,
// and offset and saturation into the queue. Samples wait in an eight-entry output
// queue; the tick channel drops ready only when the queued samples plus the requests still
// in the pipeline could fill that queue. Registers are written through the configuration
// channel, which is always ready; write them only while the block is idle. POINTS must be
// a power of two between 8 and 256, DAC_BITS between 8 and 16.
module table_waveform_generator #(
    parameter int POINTS   = 32,
    parameter int DAC_BITS = 12
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    twg_tick_if.sink      i_tick_if,
    twg_cfg_if.sink       i_cfg_if,
    twg_sample_if.source  o_sample_if
);

    localparam int PW      = $clog2(POINTS);
    localparam int MID_W   = DAC_BITS - 1;
    localparam int MW      = 16 + MID_W;
    localparam int VW      = PW + 2;
    localparam int TW      = 17 + VW;
    localparam int SPW     = MW + 1 + 17;
    localparam int DW      = DAC_BITS + 3;
    localparam int TRI_SH  = 14 + PW - DAC_BITS;

    localparam int FIFO_DEPTH = 8;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [MID_W-1:0]     MID      = MID_W'((1 << (DAC_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] MID_S    = DW'((1 << (DAC_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] MAX_S    = DW'((1 << DAC_BITS) - 1);
    localparam logic [PW-1:0]        HALF     = PW'(POINTS / 2);
    localparam logic [PW-1:0]        LAST     = PW'(POINTS - 1);
    localparam logic [PW:0]          PTS      = (PW + 1)'(POINTS);
    localparam logic signed [VW-1:0] TRI_OFS  = VW'(POINTS / 4 - 1);

    typedef struct packed {
        logic [DAC_BITS-1:0] sample;
        logic [PW-1:0]       phase;
    } t_result;

    // configuration registers
    logic                r_run_enable;
    twg_pkg::t_wave      r_wave_select;
    logic [15:0]         r_reload_period;
    logic [15:0]         r_amplitude;

    // counter state
    logic [15:0]         r_tick_count;
    logic [15:0]         n_tick_count;
    logic [PW-1:0]       r_phase_index;
    logic [PW-1:0]       n_phase_index;

    // pipeline
    logic                r_in_valid;
    logic                r1_valid;
    logic [PW-1:0]       r1_phase;
    logic [4:0]          r1_k;
    logic                r1_pos;
    logic signed [VW-1:0] r1_v;
    twg_pkg::t_wave      r1_wave;
    logic [15:0]         r1_amp;

    logic                r2_valid;
    logic [PW-1:0]       r2_phase;
    logic [MW-1:0]       r2_m;
    logic signed [TW-1:0] r2_t;
    logic signed [16:0]  r2_s;
    logic                r2_pos;
    twg_pkg::t_wave      r2_wave;

    logic                r3_valid;
    logic [PW-1:0]       r3_phase;
    logic signed [DW-1:0] r3_delta;

    // result queue
    t_result             r_fifo [FIFO_DEPTH];
    logic [FAW-1:0]      r_wr_ptr;
    logic [FAW-1:0]      r_rd_ptr;
    logic [FCW-1:0]      r_fifo_count;

    logic                tick_accept;
    logic                update;
    logic [PW:0]         phase_inc;
    logic [PW+4:0]       phase_x32;
    logic [PW-1:0]       fold;
    logic signed [VW-1:0] tri_v;
    logic signed [SPW-1:0] sine_prod;
    logic signed [MW:0]  square_val;
    logic signed [DW-1:0] delta;
    logic signed [DW-1:0] sum;
    logic [DAC_BITS-1:0] sat_sample;
    logic [2:0]          inflight;
    logic [FCW:0]        occupancy;
    logic                push;
    logic                pop;

    assign i_cfg_if.ready = 1'b1;

    // hold a request back when the queue could not take every sample still in flight
    assign inflight  = 3'({2'b0, r_in_valid} + {2'b0, r1_valid} + {2'b0, r2_valid}
                          + {2'b0, r3_valid});
    assign occupancy = (FCW + 1)'(r_fifo_count) + (FCW + 1)'(inflight);
    assign i_tick_if.ready = (occupancy < (FCW + 1)'(FIFO_DEPTH));
    assign tick_accept = i_tick_if.valid && i_tick_if.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable    <= 1'b0;
            r_wave_select   <= twg_pkg::WAVE_SINE;
            r_reload_period <= twg_pkg::RELOAD_PERIOD_RESET;
            r_amplitude     <= twg_pkg::AMPLITUDE_RESET;
        end else if (i_cfg_if.valid) begin
            case (i_cfg_if.index)
                twg_pkg::REG_RUN_ENABLE:    r_run_enable    <= i_cfg_if.data[0];
                twg_pkg::REG_WAVE_SELECT:   r_wave_select   <= i_cfg_if.data[1:0];
                twg_pkg::REG_RELOAD_PERIOD: r_reload_period <= i_cfg_if.data;
                twg_pkg::REG_AMPLITUDE:     r_amplitude     <= i_cfg_if.data;
                default: ;
            endcase
        end
    end

    // counter stage: a tick at or above the top is an update
    assign update    = r_in_valid && r_run_enable && (r_tick_count >= r_reload_period);
    assign phase_inc = {1'b0, r_phase_index} + (PW + 1)'(1);

    always_comb begin
        n_tick_count  = r_tick_count;
        n_phase_index = r_phase_index;
        if (r_in_valid && r_run_enable) begin
            if (update) begin
                n_tick_count  = 16'd0;
                n_phase_index = (phase_inc >= PTS) ? PW'(0) : phase_inc[PW-1:0];
            end else begin
                n_tick_count  = r_tick_count + 16'd1;
            end
        end
    end

    // table entry of the 32-point sine and the folded triangle ramp
    assign phase_x32 = {r_phase_index, 5'b0};
    assign fold      = (r_phase_index < HALF) ? r_phase_index : (LAST - r_phase_index);
    assign tri_v     = $signed({2'b0, fold}) - TRI_OFS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r_tick_count  <= 16'd0;
            r_phase_index <= '0;
        end else begin
            r_in_valid    <= tick_accept && i_tick_if.tick;
            r1_valid      <= update;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r_tick_count  <= n_tick_count;
            r_phase_index <= n_phase_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_phase <= r_phase_index;
        r1_k     <= phase_x32[PW+4:PW];
        r1_pos   <= (r_phase_index < HALF);
        r1_v     <= tri_v;
        r1_wave  <= r_wave_select;
        r1_amp   <= r_amplitude;

        r2_phase <= r1_phase;
        r2_m     <= MW'(r1_amp) * MW'(MID);
        r2_t     <= TW'($signed({1'b0, r1_amp})) * TW'(r1_v);
        r2_s     <= twg_pkg::sine_q15(r1_k);
        r2_pos   <= r1_pos;
        r2_wave  <= r1_wave;

        r3_phase <= r2_phase;
        r3_delta <= delta;
    end

    // scaled deviation from midscale, floored by arithmetic shift
    assign sine_prod  = SPW'($signed({1'b0, r2_m})) * SPW'(r2_s);
    assign square_val = r2_pos ? $signed({1'b0, r2_m}) : -$signed({1'b0, r2_m});

    always_comb begin
        case (r2_wave)
            twg_pkg::WAVE_SINE:     delta = DW'(sine_prod >>> 30);
            twg_pkg::WAVE_SQUARE:   delta = DW'(square_val >>> 15);
            twg_pkg::WAVE_TRIANGLE: delta = DW'(r2_t >>> TRI_SH);
            default:                delta = '0;
        endcase
    end

    // offset and clamp to the DAC range
    assign sum = MID_S + r3_delta;

    always_comb begin
        if (sum < 0) begin
            sat_sample = '0;
        end else if (sum > MAX_S) begin
            sat_sample = MAX_S[DAC_BITS-1:0];
        end else begin
            sat_sample = sum[DAC_BITS-1:0];
        end
    end

    assign push = r3_valid;
    assign pop  = o_sample_if.valid && o_sample_if.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{sample: sat_sample, phase: r3_phase};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FAW'(1);
            end
            case ({push, pop})
                2'b10:   r_fifo_count <= r_fifo_count + FCW'(1);
                2'b01:   r_fifo_count <= r_fifo_count - FCW'(1);
                default: r_fifo_count <= r_fifo_count;
            endcase
        end
    end

    assign o_sample_if.valid  = (r_fifo_count != '0);
    assign o_sample_if.sample = r_fifo[r_rd_ptr].sample;
    assign o_sample_if.phase  = r_fifo[r_rd_ptr].phase;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the table waveform generator: directed table, random ticks.
`timescale 1ns / 1ps

module tb_top;
    import twg_pkg::*;

    localparam int  DRAIN_CYCLES = 12;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SEGMENTS     = 10;
    localparam int  SEGMENT_LIVE = 70;
    localparam int  HOLD_CYCLES  = 300;
    localparam longint MID_CODE  = 2047;
    localparam longint TOP_CODE  = 4095;
    localparam longint QUARTER_WAVE [0:8] = '{
        0, 6393, 12540, 18205, 23170, 27246, 30274, 32138, 32768
    };

    typedef struct packed {
        logic [11:0] sample;
        logic [4:0]  phase;
    } t_dac_point;

    typedef enum logic {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_cfg_index index;
        t_cfg_data  data;
        logic       tick;
        bit         typed;
        t_dac_point want;
    } t_script_row;

    logic clk;
    logic rst_n;

    twg_tick_if   tick_if ();
    twg_cfg_if    cfg_if ();
    twg_sample_if #(.DAC_BITS(12), .PHASE_W(5)) sample_if ();

    table_waveform_generator #(
        .POINTS  (32),
        .DAC_BITS(12)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_tick_if  (tick_if),
        .i_cfg_if   (cfg_if),
        .o_sample_if(sample_if)
    );

    // shadow of the block's registers and timer state
    logic        run_reg;
    t_wave       wave_reg;
    logic [15:0] period_reg;
    logic [15:0] amp_reg;
    logic [15:0] count_reg;
    logic [4:0]  phase_reg;

    t_dac_point   pending_points [$];
    t_script_row  script [$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_left;
    int errors;
    int samples_checked;
    int ticks_sent;
    int ticks_live;
    int writes_done;
    int cycle_count;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d samples still expected", $time, pending_points.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold when asked
    always @(posedge clk) begin
        if (hold_left > 0) begin
            sample_if.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else begin
            sample_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_dac_point want;
        if (rst_n && sample_if.valid && sample_if.ready) begin
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample, expected none, got sample %0d phase %0d",
                         $time, sample_if.sample, sample_if.phase);
            end else begin
                want = pending_points.pop_front();
                samples_checked++;
                if (sample_if.sample !== want.sample) begin
                    errors++;
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, want.sample, sample_if.sample);
                end
                if (sample_if.phase !== want.phase) begin
                    errors++;
                    $display("%0t: phase mismatch, expected %0d, got %0d",
                             $time, want.phase, sample_if.phase);
                end
            end
        end
    end

    // DAC code for table point pt under the current shadow settings
    function automatic logic [11:0] dac_code(input logic [4:0] pt);
        longint gain;
        longint acc;
        longint sine;
        longint ramp;
        gain = longint'(amp_reg);
        acc  = MID_CODE;
        sine = (pt[3]) ? QUARTER_WAVE[8 - pt[2:0]] : QUARTER_WAVE[pt[2:0]];
        if (pt[4]) begin
            sine = -sine;
        end
        ramp = (pt < 16) ? longint'(pt) : 31 - longint'(pt);
        ramp = ramp - 7;
        case (wave_reg)
            WAVE_SINE:     acc += (sine * gain * MID_CODE) >>> 30;
            WAVE_SQUARE:   acc += ((pt < 16 ? MID_CODE : -MID_CODE) * gain) >>> 15;
            WAVE_TRIANGLE: acc += (ramp * gain * 8192) >>> 20;
            default:       acc += 0;
        endcase
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > TOP_CODE) begin
            acc = TOP_CODE;
        end
        return acc[11:0];
    endfunction

    // wait until every expected sample is out and the pipeline has emptied
    task automatic await_quiet();
        tick_if.valid <= 1'b0;
        do @(posedge clk); while (pending_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data val);
        await_quiet();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        writes_done++;
        case (idx)
            REG_RUN_ENABLE:    run_reg    = val[0];
            REG_WAVE_SELECT:   wave_reg   = val[1:0];
            REG_RELOAD_PERIOD: period_reg = val;
            REG_AMPLITUDE:     amp_reg    = val;
            default:           ;
        endcase
    endtask

    // send one tick request and predict what it produces
    task automatic issue_tick(input logic t, input bit typed, input t_dac_point want);
        t_dac_point got;
        while ($urandom_range(99) < src_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.tick  <= t;
        do @(posedge clk); while (!tick_if.ready);
        ticks_sent++;
        if (t && run_reg) begin
            ticks_live++;
            if (count_reg < period_reg) begin
                count_reg = count_reg + 1'b1;
            end else begin
                count_reg  = '0;
                got.sample = dac_code(phase_reg);
                got.phase  = phase_reg;
                phase_reg  = phase_reg + 1'b1;
                pending_points.push_back(typed ? want : got);
            end
        end
    endtask

    function automatic void add_write(input t_cfg_index idx, input t_cfg_data val);
        t_script_row r;
        r.kind  = ROW_WRITE;
        r.index = idx;
        r.data  = val;
        r.tick  = 1'b0;
        r.typed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    function automatic void add_tick(input logic t, input bit typed,
                                     input logic [11:0] s, input logic [4:0] p);
        t_script_row r;
        r.kind        = ROW_TICK;
        r.index       = REG_RUN_ENABLE;
        r.data        = '0;
        r.tick        = t;
        r.typed       = typed;
        r.want.sample = s;
        r.want.phase  = p;
        script.push_back(r);
    endfunction

    task automatic random_segment(input int live_goal);
        int start_live;
        int sent;
        int pick;
        write_reg(REG_RUN_ENABLE, t_cfg_data'($urandom_range(99) < 88));
        write_reg(REG_WAVE_SELECT, t_cfg_data'($urandom_range(3)));
        pick = $urandom_range(9);
        if (pick < 3) begin
            write_reg(REG_RELOAD_PERIOD, 16'd0);
        end else if (pick < 8) begin
            write_reg(REG_RELOAD_PERIOD, t_cfg_data'($urandom_range(5, 1)));
        end else begin
            write_reg(REG_RELOAD_PERIOD, t_cfg_data'($urandom_range(40, 6)));
        end
        pick = $urandom_range(7);
        case (pick)
            0:       write_reg(REG_AMPLITUDE, 16'd0);
            1:       write_reg(REG_AMPLITUDE, 16'd32768);
            2:       write_reg(REG_AMPLITUDE, 16'd65535);
            default: write_reg(REG_AMPLITUDE, t_cfg_data'($urandom_range(65535)));
        endcase
        start_live = ticks_live;
        sent       = 0;
        while (ticks_live - start_live < live_goal && sent < (run_reg ? 4 * live_goal : 20)) begin
            issue_tick($urandom_range(99) < 85, 1'b0, '0);
            sent++;
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        tick_if.valid   = 1'b0;
        tick_if.tick    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_RUN_ENABLE;
        cfg_if.data     = '0;
        sample_if.ready = 1'b0;
        src_idle_pct    = 20;
        sink_idle_pct   = 69;
        hold_left       = 0;
        errors          = 0;
        samples_checked = 0;
        ticks_sent      = 0;
        ticks_live      = 0;
        writes_done     = 0;
        cycle_count     = 0;
        run_reg         = 1'b0;
        wave_reg        = WAVE_SINE;
        period_reg      = RELOAD_PERIOD_RESET;
        amp_reg         = AMPLITUDE_RESET;
        count_reg       = '0;
        phase_reg       = '0;

        // directed rows: typed values are the obvious ones (midscale, rails, zero gain)
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_write(REG_RUN_ENABLE, 16'd1);
        add_write(REG_RELOAD_PERIOD, 16'd0);
        add_tick(1'b1, 1'b1, 12'd2047, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b0, 1'b0, 12'd0, 5'd0);
        add_write(REG_WAVE_SELECT, 16'(WAVE_SQUARE));
        add_tick(1'b1, 1'b1, 12'd4094, 5'd2);
        add_write(REG_AMPLITUDE, 16'd65535);
        add_tick(1'b1, 1'b1, 12'd4095, 5'd3);
        add_write(REG_WAVE_SELECT, 16'(WAVE_TRIANGLE));
        add_write(REG_AMPLITUDE, 16'd32768);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_write(REG_AMPLITUDE, 16'd0);
        add_tick(1'b1, 1'b1, 12'd2047, 5'd5);
        add_write(REG_WAVE_SELECT, 16'(WAVE_FLAT));
        add_write(REG_AMPLITUDE, 16'd65535);
        add_tick(1'b1, 1'b1, 12'd2047, 5'd6);
        add_write(REG_WAVE_SELECT, 16'(WAVE_TRIANGLE));
        add_tick(1'b1, 1'b1, 12'd2047, 5'd7);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_write(REG_RUN_ENABLE, 16'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b0, 1'b0, 12'd0, 5'd0);
        add_write(REG_RUN_ENABLE, 16'd1);
        // park the counter part way up, then drop the top below it
        add_write(REG_RELOAD_PERIOD, 16'd65535);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_write(REG_RELOAD_PERIOD, 16'd1);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_write(REG_WAVE_SELECT, 16'(WAVE_SINE));
        add_write(REG_RELOAD_PERIOD, 16'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);
        add_tick(1'b1, 1'b0, 12'd0, 5'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[n]) begin
            if (script[n].kind == ROW_WRITE) begin
                write_reg(script[n].index, script[n].data);
            end else begin
                issue_tick(script[n].tick, script[n].typed, script[n].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 4) begin
                src_idle_pct  = 69;
                sink_idle_pct = 20;
            end else if (seg == 7) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            random_segment(SEGMENT_LIVE);
        end

        // back-pressure: every tick fires, receiver holds off, input must stall
        write_reg(REG_RUN_ENABLE, 16'd1);
        write_reg(REG_RELOAD_PERIOD, 16'd0);
        hold_left <= HOLD_CYCLES;
        repeat (40) issue_tick(1'b1, 1'b0, '0);

        await_quiet();
        $display("Sent %0d tick requests (%0d while running) and %0d register writes;",
                 ticks_sent, ticks_live, writes_done);
        $display("checked %0d samples over all waves, gains, periods and stall patterns.",
                 samples_checked);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
